>>> hdl/inverse_bilinear_weights_assert.svh
// assertion macros for the inverse bilinear weights block
`ifndef INVERSE_BILINEAR_WEIGHTS_ASSERT_SVH
`define INVERSE_BILINEAR_WEIGHTS_ASSERT_SVH

// condition in the same cycle
`define IBW_ASSERT_IMPL(name, pre, post) \
  name: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error("ibw assertion failed");

// condition in the next cycle
`define IBW_ASSERT_NEXT(name, pre, post) \
  name: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("ibw assertion failed");

`endif

>>> hdl/ibw_pkg.sv
// shared types, constants and fixed point helpers for inverse bilinear weights
`default_nettype none
package ibw_pkg;

  localparam int FRAC_BITS   = 28;
  localparam int DIVW        = 32 + FRAC_BITS;
  localparam int QUEUE_DEPTH = 2;
  localparam int ITER_W      = 10;
  localparam int THR_W       = 16;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 16;

  localparam logic [ITER_W-1:0] ITER_RESET = ITER_W'(100);
  localparam logic [THR_W-1:0]  THR_RESET  = THR_W'(1);

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_ITER_LIMIT = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_CONV_THR   = CFG_IDX_W'(1);

  localparam logic [63:0] PI_Q61 = 64'h6487ED5110B4611A;
  localparam logic signed [31:0] Q_MAX = 32'sh7FFFFFFF;
  localparam logic signed [31:0] Q_MIN = 32'sh80000000;

  // round an unsigned constant down by s bits, saturated
  function automatic logic signed [31:0] round_down_by(input logic [63:0] u, input int s);
    logic [64:0] t;
    if (s == 0) begin
      return ((u >> 1) > 64'h7FFFFFFF) ? Q_MAX : u[31:0];
    end
    t = ({1'b0, u} + (65'd1 << (s - 1))) >> s;
    return (t > 65'h7FFFFFFF) ? Q_MAX : t[31:0];
  endfunction

  localparam logic signed [31:0] TWO_PI    = round_down_by(PI_Q61, 60 - FRAC_BITS);
  localparam logic signed [31:0] THREE_PIH =
    round_down_by(64'd3 * (PI_Q61 >> 1), 61 - FRAC_BITS);
  localparam logic signed [31:0] ONE  =
    (FRAC_BITS >= 31) ? Q_MAX : 32'(64'sd1 <<< FRAC_BITS);
  localparam logic signed [31:0] HALF =
    (FRAC_BITS >= 32) ? Q_MAX : 32'(64'sd1 <<< (FRAC_BITS - 1));

  // per-item setup that the front hands to the back
  typedef struct packed {
    logic signed [32:0] plat_rel;
    logic signed [31:0] dphp0;
    logic signed [31:0] dth1;
    logic signed [31:0] dth2;
    logic signed [31:0] dth3;
    logic signed [31:0] dph1;
    logic signed [31:0] dph2;
    logic signed [31:0] dph3;
  } ibw_job_t;

  // divider request
  typedef struct packed {
    logic               start;
    logic signed [31:0] num;
    logic signed [31:0] den;
  } ibw_div_req_t;

  // saturate a wide sum to 32 bits
  function automatic logic signed [31:0] sat32(input logic signed [35:0] v);
    if (v > 36'sh07FFFFFFF) return Q_MAX;
    if (v < -36'sh080000000) return Q_MIN;
    return v[31:0];
  endfunction

  // round a raw product to the fixed point grid, saturated
  function automatic logic signed [31:0] mulq_round(input logic signed [63:0] p);
    logic signed [64:0] t;
    t = (65'(p) + (65'sd1 <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
    if (t > 65'sh07FFFFFFF) return Q_MAX;
    if (t < -65'sh080000000) return Q_MIN;
    return t[31:0];
  endfunction

  // wrap a longitude difference by one turn
  function automatic logic signed [31:0] wrap_lon(input logic signed [33:0] d);
    logic signed [35:0] x;
    x = 36'(d);
    if (x > 36'(THREE_PIH)) x = x - 36'(TWO_PI);
    if (x < -36'(THREE_PIH)) x = x + 36'(TWO_PI);
    return sat32(x);
  endfunction

endpackage
`default_nettype wire

>>> hdl/ibw_if.sv
// channel interfaces for inverse bilinear weights
`default_nettype none
interface ibw_in_if;
  logic valid;
  logic ready;
  logic signed [31:0] point_lon;
  logic signed [31:0] point_lat;
  logic signed [31:0] corner_lon_0;
  logic signed [31:0] corner_lon_1;
  logic signed [31:0] corner_lon_2;
  logic signed [31:0] corner_lon_3;
  logic signed [31:0] corner_lat_0;
  logic signed [31:0] corner_lat_1;
  logic signed [31:0] corner_lat_2;
  logic signed [31:0] corner_lat_3;
  modport source (output valid, point_lon, point_lat, corner_lon_0, corner_lon_1,
    corner_lon_2, corner_lon_3, corner_lat_0, corner_lat_1, corner_lat_2,
    corner_lat_3, input ready);
  modport sink (input valid, point_lon, point_lat, corner_lon_0, corner_lon_1,
    corner_lon_2, corner_lon_3, corner_lat_0, corner_lat_1, corner_lat_2,
    corner_lat_3, output ready);
endinterface

interface ibw_out_if;
  logic valid;
  logic ready;
  logic signed [31:0] coord_i;
  logic signed [31:0] coord_j;
  logic found;
  logic signed [31:0] weight_0;
  logic signed [31:0] weight_1;
  logic signed [31:0] weight_2;
  logic signed [31:0] weight_3;
  modport source (output valid, coord_i, coord_j, found, weight_0, weight_1,
    weight_2, weight_3, input ready);
  modport sink (input valid, coord_i, coord_j, found, weight_0, weight_1,
    weight_2, weight_3, output ready);
endinterface

interface ibw_cfg_if;
  logic valid;
  logic ready;
  logic [ibw_pkg::CFG_IDX_W-1:0]  index;
  logic [ibw_pkg::CFG_DATA_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

>>> hdl/ibw_front.sv
// front part: accepts a transaction and forms the cell differences
`default_nettype none
module ibw_front (
  ibw_in_if.sink             in,
  input  wire logic          full,
  output logic               push,
  output ibw_pkg::ibw_job_t  job
);
  import ibw_pkg::*;

  logic signed [31:0] dth2;
  logic signed [31:0] dph2;

  // accept whenever the queue has room
  assign in.ready = !full;
  assign push     = in.valid && !full;

  // latitude and wrapped longitude differences
  assign dth2 = sat32(36'(in.corner_lat_3) - 36'(in.corner_lat_0));
  assign dph2 = wrap_lon(34'(in.corner_lon_3) - 34'(in.corner_lon_0));

  always_comb begin
    job.plat_rel = 33'(in.point_lat) - 33'(in.corner_lat_0);
    job.dphp0    = wrap_lon(34'(in.point_lon) - 34'(in.corner_lon_0));
    job.dth1     = sat32(36'(in.corner_lat_1) - 36'(in.corner_lat_0));
    job.dth2     = dth2;
    job.dth3     = sat32(36'(in.corner_lat_2) - 36'(in.corner_lat_1) - 36'(dth2));
    job.dph1     = wrap_lon(34'(in.corner_lon_1) - 34'(in.corner_lon_0));
    job.dph2     = dph2;
    job.dph3     = sat32(36'(wrap_lon(34'(in.corner_lon_2) - 34'(in.corner_lon_1)))
                         - 36'(dph2));
  end
endmodule
`default_nettype wire

>>> hdl/ibw_queue.sv
// short queue between front and back
`default_nettype none
module ibw_queue #(
  parameter int DEPTH = ibw_pkg::QUEUE_DEPTH
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              push,
  input  wire ibw_pkg::ibw_job_t push_data,
  output logic                   full,
  input  wire logic              pop,
  output logic                   valid,
  output ibw_pkg::ibw_job_t      head
);
  import ibw_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  ibw_job_t        slots [DEPTH];
  logic [PW-1:0]   wr_ptr;
  logic [PW-1:0]   rd_ptr;
  logic [CW-1:0]   count;

  assign full  = (count == CW'(DEPTH));
  assign valid = (count != '0);
  assign head  = slots[rd_ptr];

  // storage
  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= push_data;
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      if (pop)  rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      if (push && !pop) count <= count + CW'(1);
      else if (pop && !push) count <= count - CW'(1);
    end
  end
endmodule
`default_nettype wire

>>> hdl/ibw_div.sv
// restoring fixed point divider, one quotient bit per cycle
`default_nettype none
module ibw_div (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire ibw_pkg::ibw_div_req_t req,
  output logic                      done,
  output logic signed [31:0]        quo
);
  import ibw_pkg::*;

  localparam int CNTW = $clog2(DIVW + 1);

  logic            busy;
  logic            neg;
  logic [31:0]     ud;
  logic [31:0]     rem;
  logic [DIVW-1:0] dvd;
  logic [DIVW-1:0] q;
  logic [CNTW-1:0] cnt;
  logic [32:0]     trial;
  logic            fits;
  logic            big;

  assign trial = {rem, dvd[DIVW-1]};
  assign fits  = (trial >= {1'b0, ud});
  assign big   = |q[DIVW-1:31];

  // quotient saturated to the signed range
  always_comb begin
    if (neg) quo = big ? Q_MIN : -$signed(q[31:0]);
    else     quo = big ? Q_MAX : $signed(q[31:0]);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start && !busy) begin
        busy <= 1'b1;
        cnt  <= '0;
        neg  <= req.num[31] ^ req.den[31];
        ud   <= req.den[31] ? 32'(-req.den) : 32'(req.den);
        dvd  <= {(req.num[31] ? 32'(-req.num) : 32'(req.num)), {FRAC_BITS{1'b0}}};
        rem  <= '0;
        q    <= '0;
      end else if (busy) begin
        // one restoring step
        rem <= fits ? 32'(trial - {1'b0, ud}) : trial[31:0];
        q   <= {q[DIVW-2:0], fits};
        dvd <= {dvd[DIVW-2:0], 1'b0};
        cnt <= cnt + CNTW'(1);
        if (cnt == CNTW'(DIVW - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
endmodule
`default_nettype wire

>>> hdl/ibw_back.sv
// back part: newton sequencer on one shared multiplier and the divider
`default_nettype none
module ibw_back (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   job_valid,
  input  wire ibw_pkg::ibw_job_t      job_in,
  output logic                        pop,
  input  wire logic [ibw_pkg::ITER_W-1:0] iter_limit,
  input  wire logic [ibw_pkg::THR_W-1:0]  conv_thr,
  ibw_out_if.source                   out
);
  import ibw_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_MUL, S_WAIT, S_COMB_A, S_COMB_B, S_DIV_I, S_DIV_J, S_CHECK, S_DONE
  } state_t;

  // multiplier steps, also the product slot each one fills
  typedef enum logic [4:0] {
    ST_IJ, ST_DTH1_I, ST_DTH2_J, ST_DPH1_I, ST_DPH2_J, ST_DTH3_J, ST_DTH3_I,
    ST_DPH3_J, ST_DPH3_I, ST_DTH3_IJ, ST_DPH3_IJ, ST_M1_M4, ST_M2_M3,
    ST_THP_M4, ST_PHP_M2, ST_PHP_M1, ST_THP_M3, ST_W0, ST_W1, ST_W2, ST_W3
  } step_t;

  state_t             state;
  state_t             ret;
  step_t              st;
  step_t              last;
  step_t              ptag;
  logic               pv;
  logic signed [63:0] prod;
  logic signed [31:0] p [21];
  ibw_job_t           j;
  logic signed [31:0] gi, gj, dthp, dphp, m1, m2, m3, m4, det, nj, deli, omi, omj;
  logic [ITER_W-1:0]  iter;
  logic               found;
  logic signed [31:0] mul_a, mul_b;
  logic signed [31:0] det_c, ni_c, nj_c;
  logic [32:0]        ai, aj;
  logic [ITER_W:0]    iter_next;
  ibw_div_req_t       dreq;
  logic               ddone;
  logic signed [31:0] dquo;

  logic               ovalid;
  logic signed [31:0] o_i, o_j, o_w0, o_w1, o_w2, o_w3;
  logic               o_found;
  logic               out_free;

  assign out.valid    = ovalid;
  assign out.coord_i  = o_i;
  assign out.coord_j  = o_j;
  assign out.found    = o_found;
  assign out.weight_0 = o_w0;
  assign out.weight_1 = o_w1;
  assign out.weight_2 = o_w2;
  assign out.weight_3 = o_w3;
  assign out_free     = !ovalid || out.ready;

  assign pop = (state == S_IDLE) && job_valid;

  // operand select for the shared multiplier
  always_comb begin
    case (st)
      ST_IJ:      begin mul_a = gi;     mul_b = gj;   end
      ST_DTH1_I:  begin mul_a = j.dth1; mul_b = gi;   end
      ST_DTH2_J:  begin mul_a = j.dth2; mul_b = gj;   end
      ST_DPH1_I:  begin mul_a = j.dph1; mul_b = gi;   end
      ST_DPH2_J:  begin mul_a = j.dph2; mul_b = gj;   end
      ST_DTH3_J:  begin mul_a = j.dth3; mul_b = gj;   end
      ST_DTH3_I:  begin mul_a = j.dth3; mul_b = gi;   end
      ST_DPH3_J:  begin mul_a = j.dph3; mul_b = gj;   end
      ST_DPH3_I:  begin mul_a = j.dph3; mul_b = gi;   end
      ST_DTH3_IJ: begin mul_a = j.dth3; mul_b = p[ST_IJ]; end
      ST_DPH3_IJ: begin mul_a = j.dph3; mul_b = p[ST_IJ]; end
      ST_M1_M4:   begin mul_a = m1;     mul_b = m4;   end
      ST_M2_M3:   begin mul_a = m2;     mul_b = m3;   end
      ST_THP_M4:  begin mul_a = dthp;   mul_b = m4;   end
      ST_PHP_M2:  begin mul_a = dphp;   mul_b = m2;   end
      ST_PHP_M1:  begin mul_a = dphp;   mul_b = m1;   end
      ST_THP_M3:  begin mul_a = dthp;   mul_b = m3;   end
      ST_W0:      begin mul_a = omi;    mul_b = omj;  end
      ST_W1:      begin mul_a = gi;     mul_b = omj;  end
      ST_W2:      begin mul_a = gi;     mul_b = gj;   end
      ST_W3:      begin mul_a = omi;    mul_b = gj;   end
      default:    begin mul_a = '0;     mul_b = '0;   end
    endcase
  end

  // determinant and numerators from the second product group
  assign det_c = sat32(36'(p[ST_M1_M4]) - 36'(p[ST_M2_M3]));
  assign ni_c  = sat32(36'(p[ST_THP_M4]) - 36'(p[ST_PHP_M2]));
  assign nj_c  = sat32(36'(p[ST_PHP_M1]) - 36'(p[ST_THP_M3]));

  // correction magnitudes
  assign ai = deli[31] ? 33'(-34'(deli)) : 33'(deli);
  assign aj = dquo[31] ? 33'(-34'(dquo)) : 33'(dquo);
  assign iter_next = {1'b0, iter} + (ITER_W + 1)'(1);

  // divider requests
  always_comb begin
    dreq.start = 1'b0;
    dreq.num   = nj;
    dreq.den   = det;
    if (state == S_COMB_B) begin
      dreq.start = (det_c != '0);
      dreq.num   = ni_c;
      dreq.den   = det_c;
    end else if (state == S_DIV_I) begin
      dreq.start = ddone;
    end
  end

  ibw_div u_div (
    .clk  (clk),
    .rst  (rst),
    .req  (dreq),
    .done (ddone),
    .quo  (dquo)
  );

  // multiplier pipeline: raw product, then rounded into its slot
  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
    ptag <= st;
    if (pv) p[ptag] <= mulq_round(prod);
  end

  // sequencer and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      ovalid <= 1'b0;
      pv     <= 1'b0;
      st     <= ST_IJ;
      last   <= ST_IJ;
      ret    <= S_IDLE;
    end else begin
      pv <= (state == S_MUL);
      if (out.ready && state != S_DONE) ovalid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (job_valid) begin
            j     <= job_in;
            gi    <= HALF;
            gj    <= HALF;
            iter  <= '0;
            found <= 1'b0;
            st    <= ST_IJ;
            last  <= ST_DPH3_IJ;
            ret   <= S_COMB_A;
            state <= (iter_limit == '0) ? S_DONE : S_MUL;
          end
        end
        S_MUL: begin
          if (st == last) state <= S_WAIT;
          else st <= step_t'(st + 5'd1);
        end
        S_WAIT: begin
          state <= ret;
        end
        S_COMB_A: begin
          dthp <= sat32(36'(j.plat_rel) - 36'(p[ST_DTH1_I]) - 36'(p[ST_DTH2_J])
                        - 36'(p[ST_DTH3_IJ]));
          dphp <= sat32(36'(j.dphp0) - 36'(p[ST_DPH1_I]) - 36'(p[ST_DPH2_J])
                        - 36'(p[ST_DPH3_IJ]));
          m1    <= sat32(36'(j.dth1) + 36'(p[ST_DTH3_J]));
          m2    <= sat32(36'(j.dth2) + 36'(p[ST_DTH3_I]));
          m3    <= sat32(36'(j.dph1) + 36'(p[ST_DPH3_J]));
          m4    <= sat32(36'(j.dph2) + 36'(p[ST_DPH3_I]));
          st    <= ST_M1_M4;
          last  <= ST_THP_M3;
          ret   <= S_COMB_B;
          state <= S_MUL;
        end
        S_COMB_B: begin
          det <= det_c;
          nj  <= nj_c;
          state <= (det_c == '0) ? S_DONE : S_DIV_I;
        end
        S_DIV_I: begin
          if (ddone) begin
            deli  <= dquo;
            state <= S_DIV_J;
          end
        end
        S_DIV_J: begin
          if (ddone) state <= S_CHECK;
        end
        S_CHECK: begin
          // delj is still on the divider output here
          if (ai < 33'(conv_thr) && aj < 33'(conv_thr)) begin
            found <= 1'b1;
            omi   <= sat32(36'(ONE) - 36'(gi));
            omj   <= sat32(36'(ONE) - 36'(gj));
            st    <= ST_W0;
            last  <= ST_W3;
            ret   <= S_DONE;
            state <= S_MUL;
          end else begin
            gi   <= sat32(36'(gi) + 36'(deli));
            gj   <= sat32(36'(gj) + 36'(dquo));
            iter <= iter_next[ITER_W-1:0];
            if (iter_next >= {1'b0, iter_limit}) begin
              state <= S_DONE;
            end else begin
              st    <= ST_IJ;
              last  <= ST_DPH3_IJ;
              ret   <= S_COMB_A;
              state <= S_MUL;
            end
          end
        end
        S_DONE: begin
          if (out_free) begin
            ovalid  <= 1'b1;
            o_i     <= gi;
            o_j     <= gj;
            o_found <= found;
            o_w0    <= found ? p[ST_W0] : '0;
            o_w1    <= found ? p[ST_W1] : '0;
            o_w2    <= found ? p[ST_W2] : '0;
            o_w3    <= found ? p[ST_W3] : '0;
            state   <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

>>> hdl/inverse_bilinear_weights.sv
// top level of the inverse bilinear weights block
//
//  channel  dir  handshake      payload
//  in       in   valid/ready    point and four corners, Q4.28 radians
//  out      out  valid/ready    coord_i, coord_j, found, weight_0..3
//  cfg      in   valid/ready    index, data (ready always high)
//
// Each Newton iteration runs 11 and then 6 steps through the one shared
// multiplier, each group followed by a drain and a combine state, then two
// divisions in the serial divider and a check state.
// An item also passes the pop, the weights and the output register. Reset is
// synchronous and empties queue and sequencer. The front keeps accepting into
// the queue while it has room, while the back works or while a result waits on
// out; the back stalls only when a new result finds out full.
`default_nettype none
`include "inverse_bilinear_weights_assert.svh"
module inverse_bilinear_weights #(
  parameter int QDEPTH = ibw_pkg::QUEUE_DEPTH
) (
  input  wire logic clk,
  input  wire logic rst,
  ibw_in_if.sink    in,
  ibw_out_if.source out,
  ibw_cfg_if.sink   cfg
);
  import ibw_pkg::*;

  logic [ITER_W-1:0] iter_limit;
  logic [THR_W-1:0]  conv_thr;
  logic              q_push, q_full, q_pop, q_valid;
  ibw_job_t          f_job, q_head;
  logic              w_zero;

  // configuration registers
  assign cfg.ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      iter_limit <= ITER_RESET;
      conv_thr   <= THR_RESET;
    end else if (cfg.valid) begin
      if (cfg.index == REG_ITER_LIMIT) iter_limit <= cfg.data[ITER_W-1:0];
      if (cfg.index == REG_CONV_THR)   conv_thr   <= cfg.data[THR_W-1:0];
    end
  end

  ibw_front u_front (
    .in   (in),
    .full (q_full),
    .push (q_push),
    .job  (f_job)
  );

  ibw_queue #(.DEPTH(QDEPTH)) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (f_job),
    .full      (q_full),
    .pop       (q_pop),
    .valid     (q_valid),
    .head      (q_head)
  );

  ibw_back u_back (
    .clk        (clk),
    .rst        (rst),
    .job_valid  (q_valid),
    .job_in     (q_head),
    .pop        (q_pop),
    .iter_limit (iter_limit),
    .conv_thr   (conv_thr),
    .out        (out)
  );

  // all four weights zero
  assign w_zero = (out.weight_0 == '0) && (out.weight_1 == '0) &&
                  (out.weight_2 == '0) && (out.weight_3 == '0);

  // checks
  `IBW_ASSERT_IMPL(a_no_push_full, q_push, !q_full)
  `IBW_ASSERT_IMPL(a_pop_has_item, q_pop, q_valid)
  `IBW_ASSERT_IMPL(a_not_found_zero, out.valid && !out.found, w_zero)
  `IBW_ASSERT_NEXT(a_pop_then_busy, q_pop, !q_pop)

endmodule
`default_nettype wire

>>> tb/ibw_checker.sv
// checker for inverse bilinear weights: predicts each result and compares it
`default_nettype none
module ibw_checker (
  input  wire logic clk,
  input  wire logic rst,
  ibw_in_if         in_ch,
  ibw_out_if        out_ch,
  ibw_cfg_if        cfg_ch,
  output int        mismatches,
  output int        pending
);
  import ibw_pkg::*;

  typedef struct packed {
    logic signed [31:0] coord_i;
    logic signed [31:0] coord_j;
    logic               found;
    logic signed [31:0] weight_0;
    logic signed [31:0] weight_1;
    logic signed [31:0] weight_2;
    logic signed [31:0] weight_3;
  } weights_t;

  logic [ITER_W-1:0] iter_limit;
  logic [THR_W-1:0]  conv_thr;
  weights_t          expected_weights[$];

  // clamp to the signed 32-bit range
  function automatic longint clamp32(input longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  // fixed point product, round half up, saturated
  function automatic longint fx_mul(input longint a, input longint b);
    longint p;
    p = a * b + (64'sd1 <<< (FRAC_BITS - 1));
    return clamp32(p >>> FRAC_BITS);
  endfunction

  // fixed point quotient, truncated toward zero, saturated
  function automatic longint fx_div(input longint n, input longint d);
    bit neg;
    longint unsigned un, ud, q, rem;
    longint r;
    neg = (n < 0) != (d < 0);
    un = (n < 0) ? -n : n;
    ud = (d < 0) ? -d : d;
    q = un / ud;
    rem = un % ud;
    for (int k = 0; k < FRAC_BITS; k++) begin
      if (q > 64'd4294967296) break;
      rem = rem << 1;
      q = q << 1;
      if (rem >= ud) begin
        rem = rem - ud;
        q = q | 64'd1;
      end
    end
    if (q > 64'd4294967296) q = 64'd4294967296;
    r = q;
    return clamp32(neg ? -r : r);
  endfunction

  // wrap a longitude difference by one turn
  function automatic longint lon_wrap(input longint d);
    longint tp, th;
    tp = longint'(TWO_PI);
    th = longint'(THREE_PIH);
    if (d > th) d = d - tp;
    if (d < -th) d = d + tp;
    return clamp32(d);
  endfunction

  // newton solve of the local coordinates, then corner weights
  function automatic weights_t solve_cell(input longint v[10], input longint lim,
                                          input longint thr);
    weights_t r;
    longint dth1, dth2, dth3, dph1, dph2, dph3, gi, gj;
    longint ij, dthp, dphp, m1, m2, m3, m4, det, deli, delj, ai, aj, omi, omj;
    bit hit;
    hit = 0;
    dth1 = clamp32(v[7] - v[6]);
    dth2 = clamp32(v[9] - v[6]);
    dth3 = clamp32(v[8] - v[7] - dth2);
    dph1 = lon_wrap(v[3] - v[2]);
    dph2 = lon_wrap(v[5] - v[2]);
    dph3 = lon_wrap(v[4] - v[3]);
    dph3 = clamp32(dph3 - dph2);
    gi = longint'(HALF);
    gj = longint'(HALF);
    for (longint it = 0; it < lim; it++) begin
      ij = fx_mul(gi, gj);
      dthp = clamp32(v[1] - v[6] - fx_mul(dth1, gi) - fx_mul(dth2, gj) - fx_mul(dth3, ij));
      dphp = lon_wrap(v[0] - v[2]);
      dphp = clamp32(dphp - fx_mul(dph1, gi) - fx_mul(dph2, gj) - fx_mul(dph3, ij));
      m1 = clamp32(dth1 + fx_mul(dth3, gj));
      m2 = clamp32(dth2 + fx_mul(dth3, gi));
      m3 = clamp32(dph1 + fx_mul(dph3, gj));
      m4 = clamp32(dph2 + fx_mul(dph3, gi));
      det = clamp32(fx_mul(m1, m4) - fx_mul(m2, m3));
      if (det == 0) break;
      deli = fx_div(clamp32(fx_mul(dthp, m4) - fx_mul(dphp, m2)), det);
      delj = fx_div(clamp32(fx_mul(dphp, m1) - fx_mul(dthp, m3)), det);
      ai = (deli < 0) ? -deli : deli;
      aj = (delj < 0) ? -delj : delj;
      if (ai < thr && aj < thr) begin
        hit = 1;
        break;
      end
      gi = clamp32(gi + deli);
      gj = clamp32(gj + delj);
    end
    r = '0;
    r.coord_i = gi[31:0];
    r.coord_j = gj[31:0];
    r.found = hit;
    if (hit) begin
      omi = clamp32(longint'(ONE) - gi);
      omj = clamp32(longint'(ONE) - gj);
      r.weight_0 = 32'(fx_mul(omi, omj));
      r.weight_1 = 32'(fx_mul(gi, omj));
      r.weight_2 = 32'(fx_mul(gi, gj));
      r.weight_3 = 32'(fx_mul(omi, gj));
    end
    return r;
  endfunction

  // track registers, predict on input transactions, compare on output ones
  always @(posedge clk) begin
    longint v[10];
    weights_t got, want;
    if (rst) begin
      iter_limit <= ITER_RESET;
      conv_thr <= THR_RESET;
      expected_weights.delete();
      mismatches = 0;
    end else begin
      if (cfg_ch.valid && cfg_ch.ready) begin
        if (cfg_ch.index == REG_ITER_LIMIT) iter_limit <= cfg_ch.data[ITER_W-1:0];
        else if (cfg_ch.index == REG_CONV_THR) conv_thr <= cfg_ch.data[THR_W-1:0];
      end
      if (in_ch.valid && in_ch.ready) begin
        v[0] = longint'(in_ch.point_lon);    v[1] = longint'(in_ch.point_lat);
        v[2] = longint'(in_ch.corner_lon_0); v[3] = longint'(in_ch.corner_lon_1);
        v[4] = longint'(in_ch.corner_lon_2); v[5] = longint'(in_ch.corner_lon_3);
        v[6] = longint'(in_ch.corner_lat_0); v[7] = longint'(in_ch.corner_lat_1);
        v[8] = longint'(in_ch.corner_lat_2); v[9] = longint'(in_ch.corner_lat_3);
        expected_weights.push_back(solve_cell(v, longint'(iter_limit), longint'(conv_thr)));
      end
      if (out_ch.valid && out_ch.ready) begin
        got.coord_i = out_ch.coord_i;   got.coord_j = out_ch.coord_j;
        got.found = out_ch.found;
        got.weight_0 = out_ch.weight_0; got.weight_1 = out_ch.weight_1;
        got.weight_2 = out_ch.weight_2; got.weight_3 = out_ch.weight_3;
        if (expected_weights.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result transaction i=%h j=%h", got.coord_i,
                                         got.coord_j);
        end else begin
          want = expected_weights.pop_front();
          if (got !== want) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("mismatch exp i=%h j=%h f=%b w=%h %h %h %h", want.coord_i, want.coord_j,
                       want.found, want.weight_0, want.weight_1, want.weight_2, want.weight_3);
              $display("         got i=%h j=%h f=%b w=%h %h %h %h", got.coord_i, got.coord_j,
                       got.found, got.weight_0, got.weight_1, got.weight_2, got.weight_3);
            end
          end
        end
      end
    end
    pending <= expected_weights.size();
  end
endmodule
`default_nettype wire

>>> tb/inverse_bilinear_weights_tb.sv
// testbench top for inverse bilinear weights: stimulus, stalls and verdict
`default_nettype none
module inverse_bilinear_weights_tb;
  import ibw_pkg::*;

  typedef longint cell_t [10];

  logic clk;
  logic rst;
  int   mismatches;
  int   pending;
  bit   calm;
  int   out_stall;

  ibw_in_if  in_ch ();
  ibw_out_if out_ch ();
  ibw_cfg_if cfg_ch ();

  inverse_bilinear_weights u_top (.clk(clk), .rst(rst), .in(in_ch), .out(out_ch), .cfg(cfg_ch));

  ibw_checker u_checker (.clk(clk), .rst(rst), .in_ch(in_ch), .out_ch(out_ch), .cfg_ch(cfg_ch),
                         .mismatches(mismatches), .pending(pending));

  // clock
  initial begin
    clk = 0;
    forever #10 clk = ~clk;
  end

  // run limit
  initial begin
    #400000000;
    $display("FAIL inverse_bilinear_weights");
    $finish;
  end

  // receiver stalls in bursts
  always @(posedge clk) begin
    if (rst || calm) begin
      out_ch.ready <= !rst;
      out_stall = 0;
    end else if (out_stall > 0) begin
      out_stall--;
      out_ch.ready <= 0;
    end else if ($urandom_range(0, 7) == 0) begin
      out_stall = $urandom_range(1, 6) - 1;
      out_ch.ready <= 0;
    end else begin
      out_ch.ready <= 1;
    end
  end

  // one input transaction, with an optional idle burst first
  task automatic send_cell(input cell_t c);
    if (!calm && $urandom_range(0, 3) == 0) begin
      in_ch.valid <= 0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_ch.valid <= 1;
    in_ch.point_lon <= 32'(c[0]);    in_ch.point_lat <= 32'(c[1]);
    in_ch.corner_lon_0 <= 32'(c[2]); in_ch.corner_lon_1 <= 32'(c[3]);
    in_ch.corner_lon_2 <= 32'(c[4]); in_ch.corner_lon_3 <= 32'(c[5]);
    in_ch.corner_lat_0 <= 32'(c[6]); in_ch.corner_lat_1 <= 32'(c[7]);
    in_ch.corner_lat_2 <= 32'(c[8]); in_ch.corner_lat_3 <= 32'(c[9]);
    do @(posedge clk); while (!in_ch.ready);
  endtask

  // hold the sender until every result is back
  task automatic drain;
    in_ch.valid <= 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  // one register write, valid left high for a following write
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_ch.valid <= 1;
    cfg_ch.index <= idx;
    cfg_ch.data <= val;
    do @(posedge clk); while (!cfg_ch.ready);
  endtask

  task automatic set_regs(input int lim, input int thr);
    drain();
    write_reg(REG_ITER_LIMIT, {6'($urandom), 10'(lim)});
    write_reg(REG_CONV_THR, 16'(thr));
    cfg_ch.valid <= 0;
  endtask

  // a regular cell with the point near it, optionally straddling the dateline
  function automatic cell_t regular_cell(input bit dateline);
    cell_t c;
    longint x, y, dx, dy, jx, jy, pi_q;
    pi_q = longint'(TWO_PI) / 2;
    dx = (64'sd1 <<< $urandom_range(18, 26)) + $urandom_range(0, 65535);
    dy = (64'sd1 <<< $urandom_range(18, 26)) + $urandom_range(0, 65535);
    jx = longint'($urandom_range(0, 32'(dx / 8))) - dx / 16;
    jy = longint'($urandom_range(0, 32'(dy / 8))) - dy / 16;
    x = dateline ? pi_q - dx / 2 : longint'($urandom_range(0, 1600000000)) - 800000000;
    y = longint'($urandom_range(0, 800000000)) - 400000000;
    c[2] = x;           c[3] = x + dx + jx;  c[4] = x + dx;  c[5] = x + jx;
    c[6] = y;           c[7] = y + jy;       c[8] = y + dy;  c[9] = y + dy + jy;
    c[0] = x + (longint'($urandom_range(0, 300)) - 20) * dx / 256;
    c[1] = y + (longint'($urandom_range(0, 300)) - 20) * dy / 256;
    for (int k = 0; k < 6; k++)
      if (k != 1 && c[k] > pi_q) c[k] = c[k] - longint'(TWO_PI);
    return c;
  endfunction

  // mixed random cells: mostly regular, some noise, some degenerate
  function automatic cell_t random_cell;
    cell_t c;
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 65) begin
      c = regular_cell(0);
    end else if (pick < 75) begin
      c = regular_cell(1);
    end else if (pick < 90) begin
      for (int k = 0; k < 10; k++) c[k] = longint'(signed'(32'($urandom)));
    end else begin
      c = regular_cell(0);
      if (pick < 95) begin
        c[3] = c[2]; c[4] = c[5]; c[7] = c[6]; c[8] = c[9];
      end else begin
        c[5] = c[2]; c[9] = c[6]; c[4] = c[3]; c[8] = c[7];
      end
    end
    return c;
  endfunction

  task automatic run_random(input int n);
    for (int k = 0; k < n; k++) send_cell(random_cell());
  endtask

  function automatic cell_t filled(input longint v);
    cell_t c;
    for (int k = 0; k < 10; k++) c[k] = v;
    return c;
  endfunction

  // main sequence
  initial begin
    cell_t c;
    rst = 1;
    calm = 0;
    in_ch.valid = 0;
    in_ch.point_lon = 0;    in_ch.point_lat = 0;
    in_ch.corner_lon_0 = 0; in_ch.corner_lon_1 = 0;
    in_ch.corner_lon_2 = 0; in_ch.corner_lon_3 = 0;
    in_ch.corner_lat_0 = 0; in_ch.corner_lat_1 = 0;
    in_ch.corner_lat_2 = 0; in_ch.corner_lat_3 = 0;
    out_ch.ready = 0;
    cfg_ch.valid = 0;
    cfg_ch.index = REG_ITER_LIMIT;
    cfg_ch.data = 0;
    repeat (7) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // reset settings, regular cells only
    for (int k = 0; k < 4; k++) send_cell(regular_cell(k == 3));

    // limit zero: no iteration runs
    set_regs(0, 65535);
    send_cell(filled(0));
    run_random(8);

    // directed extremes with a short limit
    set_regs(2, 65535);
    send_cell(filled(0));                     // zero determinant
    send_cell(filled(64'sd2147483647));
    send_cell(filled(-64'sd2147483648));
    c = regular_cell(0); c[0] = 64'sd2147483647;  c[1] = -64'sd2147483648; send_cell(c);
    c = regular_cell(0); c[0] = -64'sd2147483648; c[1] = 64'sd2147483647;  send_cell(c);
    c = filled(0); c[7] = 64'sd2147483647; c[6] = -64'sd2147483648;
    c[9] = 64'sd2147483647; c[8] = -64'sd2147483648; send_cell(c);   // saturated differences
    c = filled(0); c[3] = 64'sd2147483647; c[2] = -64'sd2147483648;
    c[5] = 64'sd1500000000; c[6] = 64'sd100; c[9] = 64'sd1 <<< 26;
    send_cell(c);                             // wrap past +3pi/2
    c = filled(0); c[3] = -64'sd2147483648; c[2] = 64'sd2147483647;
    c[5] = -64'sd1500000000; c[7] = 64'sd1 <<< 26; c[9] = 64'sd1 <<< 25;
    send_cell(c);                             // wrap past -3pi/2
    c = regular_cell(1); send_cell(c);        // cell across the dateline
    c = regular_cell(0); c[0] = c[2] + 64'sd1300000000; send_cell(c);
    c = regular_cell(0); c[0] = c[2] - 64'sd1300000000; send_cell(c);
    c = regular_cell(0); c[0] = c[2]; c[1] = c[6]; send_cell(c);   // point on corner 0
    c = regular_cell(0); c[0] = c[4]; c[1] = c[8]; send_cell(c);   // point on corner 2
    for (int k = 0; k < 6; k++) send_cell(random_cell());
    drain();                                  // sender waits for every result
    for (int k = 0; k < 4; k++) send_cell(random_cell());

    // largest limit, loose threshold, regular cells
    set_regs(1023, 65535);
    for (int k = 0; k < 3; k++) send_cell(regular_cell(k == 2));

    // threshold zero: never converges
    set_regs(6, 0);
    run_random(60);

    // random settings
    set_regs(8, 1);
    run_random(90);
    for (int p = 0; p < 6; p++) begin
      set_regs($urandom_range(1, 8), (p == 0) ? 65535 : $urandom_range(1, 65535));
      run_random(100);
    end

    // last part without stalls
    set_regs(5, $urandom_range(256, 65535));
    calm = 1;
    run_random(80);

    drain();
    repeat (200) @(posedge clk);
    if (mismatches == 0 && pending == 0) begin
      $display("PASS inverse_bilinear_weights");
    end else begin
      $display("FAIL inverse_bilinear_weights");
    end
    $finish;
  end
endmodule
`default_nettype wire

>>> filelist.f
+incdir+hdl
hdl/ibw_pkg.sv
hdl/ibw_if.sv
hdl/ibw_front.sv
hdl/ibw_queue.sv
hdl/ibw_div.sv
hdl/ibw_back.sv
hdl/inverse_bilinear_weights.sv
tb/ibw_checker.sv
tb/inverse_bilinear_weights_tb.sv
